// File: hw/rtl/por_pkg.sv
// ----------------------------------------------------------------------------
// Point-versus-oriented-box resolver package
// Control word layout, datapath status, field widths and the step program
// shared by the sequencer, the datapath and the top level.
// ----------------------------------------------------------------------------
package por_pkg;

    // Field widths
    localparam int PosW  = 32;
    localparam int TrigW = 16;
    localparam int HalfW = 20;
    localparam int ClrW  = 16;
    localparam int StepW = 4;

    // Stream payload widths (input fields packed, output padded to bytes)
    localparam int InDataW  = 2 * PosW + 2 * PosW + 2 * TrigW + 2 * HalfW;
    localparam int OutDataW = 72;

    // Sequencer state
    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    // Step operation
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIFF,
        OP_TEST,
        OP_END
    } t_op;

    // Multiplier operand selects
    typedef enum logic [1:0] {
        A_DX,
        A_DY,
        A_NLX,
        A_NLY
    } t_amux;

    typedef enum logic {
        B_COS,
        B_SIN
    } t_bmux;

    // Accumulator operation on the registered product
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_accop;

    // Destination written from the accumulator
    typedef enum logic [2:0] {
        WR_NONE,
        WR_LX,
        WR_LY,
        WR_PX,
        WR_PY
    } t_wr;

    // One control word of the step program
    typedef struct packed {
        t_op              op;
        t_amux            amux;
        t_bmux            bmux;
        logic             mul_en;
        t_accop           accop;
        t_wr              wr;
        logic             jmp_out;
        logic [StepW-1:0] target;
    } t_cw;

    // Datapath status back to the sequencer
    typedef struct packed {
        logic outside;
        logic emit_stall;
    } t_dp_status;

    localparam t_cw CW_NOP = '{
        op: OP_NOP, amux: A_DX, bmux: B_COS, mul_en: 1'b0,
        accop: ACC_HOLD, wr: WR_NONE, jmp_out: 1'b0, target: '0
    };

    localparam logic [StepW-1:0] StepEnd = StepW'(15);

    // Step program: local frame, inside test, push and return to world frame.
    function automatic t_cw por_rom(input logic [StepW-1:0] step);
        t_cw w;
        w = CW_NOP;
        case (step)
            4'd0: begin
                w.op = OP_LOAD;
            end
            4'd1: begin
                w.op = OP_DIFF;
            end
            4'd2: begin
                w.mul_en = 1'b1; w.amux = A_DX; w.bmux = B_COS;
            end
            4'd3: begin
                w.mul_en = 1'b1; w.amux = A_DY; w.bmux = B_SIN; w.accop = ACC_LOAD;
            end
            4'd4: begin
                w.mul_en = 1'b1; w.amux = A_DY; w.bmux = B_COS; w.accop = ACC_ADD;
            end
            4'd5: begin
                w.mul_en = 1'b1; w.amux = A_DX; w.bmux = B_SIN; w.accop = ACC_LOAD;
                w.wr = WR_LX;
            end
            4'd6: begin
                w.accop = ACC_SUB;
            end
            4'd7: begin
                w.wr = WR_LY;
            end
            4'd8: begin
                w.op = OP_TEST; w.jmp_out = 1'b1; w.target = StepEnd;
            end
            4'd9: begin
                w.mul_en = 1'b1; w.amux = A_NLX; w.bmux = B_COS;
            end
            4'd10: begin
                w.mul_en = 1'b1; w.amux = A_NLY; w.bmux = B_SIN; w.accop = ACC_LOAD;
            end
            4'd11: begin
                w.mul_en = 1'b1; w.amux = A_NLX; w.bmux = B_SIN; w.accop = ACC_SUB;
            end
            4'd12: begin
                w.mul_en = 1'b1; w.amux = A_NLY; w.bmux = B_COS; w.accop = ACC_LOAD;
                w.wr = WR_PX;
            end
            4'd13: begin
                w.accop = ACC_ADD;
            end
            4'd14: begin
                w.wr = WR_PY;
            end
            4'd15: begin
                w.op = OP_END;
            end
            default: begin
                w = CW_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/por_seq.sv
// ----------------------------------------------------------------------------
// Resolver step sequencer
// Step counter over the control program, with a conditional jump past the
// push steps and a hold on the final step while the result cannot leave.
// ----------------------------------------------------------------------------
module por_seq
    import por_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_cw        o_cw,
    output logic       o_idle
);

    t_seq_state       r_state, n_state;
    logic [StepW-1:0] r_step, n_step;
    t_cw              w_cw;

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next step and control word fetch
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        w_cw    = (r_state == SEQ_RUN) ? por_rom(r_step) : CW_NOP;
        case (r_state)
            SEQ_IDLE: begin
                if (i_start) begin
                    n_state = SEQ_RUN;
                    n_step  = '0;
                end
            end
            SEQ_RUN: begin
                if (w_cw.op == OP_END) begin
                    if (!i_status.emit_stall) begin
                        n_state = SEQ_IDLE;
                    end
                end else if (w_cw.jmp_out && i_status.outside) begin
                    n_step = w_cw.target;
                end else begin
                    n_step = r_step + StepW'(1);
                end
            end
            default: begin
                n_state = SEQ_IDLE;
            end
        endcase
    end

    assign o_cw   = w_cw;
    assign o_idle = (r_state == SEQ_IDLE);

endmodule

// File: hw/rtl/por_dp.sv
// ----------------------------------------------------------------------------
// Resolver datapath
// Item registers, one shared 33x16 multiplier with product register and
// accumulator, inside test and face choice, held position and result register.
// ----------------------------------------------------------------------------
module por_dp
    import por_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_first,
    input  logic                i_last,
    input  logic [InDataW-1:0]  i_data,
    input  logic                i_cfg_wr_en,
    input  logic [ClrW-1:0]     i_cfg_wr_data,
    input  t_cw                 i_cw,
    output t_dp_status          o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OutDataW-1:0] o_out_data
);

    // Captured item
    logic                    r_first, r_last;
    logic signed [PosW-1:0]  r_agent_x, r_agent_y, r_cx, r_cy;
    logic signed [TrigW-1:0] r_cos, r_sin;
    logic [HalfW-1:0]        r_half_x, r_half_y;
    logic [ClrW-1:0]         r_clr;

    // Held state
    logic signed [PosW-1:0]  r_cur_x, r_cur_y;
    logic                    r_any;

    // Working registers
    logic signed [PosW:0]    r_dx, r_dy;
    logic signed [35:0]      r_lx, r_ly;
    logic signed [21:0]      r_nlx, r_nly;
    logic signed [48:0]      r_prod;
    logic signed [49:0]      r_acc;

    // Result register
    logic                    r_out_valid;
    logic [OutDataW-1:0]     r_out_data;

    logic signed [PosW:0]    w_mul_a;
    logic signed [TrigW-1:0] w_mul_b;
    logic signed [49:0]      w_prod_x;
    logic [20:0]             w_ex, w_ey;
    logic [35:0]             w_ax, w_ay;
    logic                    w_inside;
    logic [21:0]             w_pen_x, w_pen_y;
    logic signed [21:0]      w_ex_s, w_ey_s;
    logic signed [35:0]      w_shift;
    logic signed [36:0]      w_base, w_sum;
    logic signed [PosW-1:0]  w_sat;
    logic                    w_stall;
    logic                    w_emit;

    // Multiplier operand selection
    always_comb begin
        case (i_cw.amux)
            A_DX:    w_mul_a = r_dx;
            A_DY:    w_mul_a = r_dy;
            A_NLX:   w_mul_a = {{(PosW+1-22){r_nlx[21]}}, r_nlx};
            A_NLY:   w_mul_a = {{(PosW+1-22){r_nly[21]}}, r_nly};
            default: w_mul_a = r_dx;
        endcase
        w_mul_b = (i_cw.bmux == B_SIN) ? r_sin : r_cos;
    end

    // Grown extents and the inside test on the local coordinates
    assign w_ex     = {1'b0, r_half_x} + {5'b0, r_clr};
    assign w_ey     = {1'b0, r_half_y} + {5'b0, r_clr};
    assign w_ax     = r_lx[35] ? 36'(-r_lx) : 36'(r_lx);
    assign w_ay     = r_ly[35] ? 36'(-r_ly) : 36'(r_ly);
    assign w_inside = (w_ax < {15'b0, w_ex}) && (w_ay < {15'b0, w_ey});
    assign w_pen_x  = {1'b0, w_ex} - {1'b0, w_ax[20:0]};
    assign w_pen_y  = {1'b0, w_ey} - {1'b0, w_ay[20:0]};
    assign w_ex_s   = $signed({1'b0, w_ex});
    assign w_ey_s   = $signed({1'b0, w_ey});

    // Back to world frame: center plus floored accumulator, saturated
    assign w_prod_x = {r_prod[48], r_prod};
    assign w_shift  = r_acc[49:14];
    assign w_base   = (i_cw.wr == WR_PY) ? {{5{r_cy[PosW-1]}}, r_cy}
                                         : {{5{r_cx[PosW-1]}}, r_cx};
    assign w_sum    = w_base + {w_shift[35], w_shift};
    always_comb begin
        if ((w_sum[36:31] == 6'b000000) || (w_sum[36:31] == 6'b111111)) begin
            w_sat = w_sum[PosW-1:0];
        end else if (w_sum[36]) begin
            w_sat = {1'b1, {(PosW-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(PosW-1){1'b1}}};
        end
    end

    // Emit handshake toward the output register
    assign w_stall = r_last && r_out_valid && !i_out_ready;
    assign w_emit  = (i_cw.op == OP_END) && r_last && !w_stall;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cfg_wr_en) begin
            r_clr <= i_cfg_wr_data;
        end
    end

    // Item capture on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_first   <= i_first;
            r_last    <= i_last;
            r_agent_x <= i_data[31:0];
            r_agent_y <= i_data[63:32];
            r_cx      <= i_data[95:64];
            r_cy      <= i_data[127:96];
            r_cos     <= i_data[143:128];
            r_sin     <= i_data[159:144];
            r_half_x  <= i_data[179:160];
            r_half_y  <= i_data[199:180];
        end
    end

    // Multiplier, accumulator and local-frame registers
    always_ff @(posedge i_clk) begin
        if (i_cw.mul_en) begin
            r_prod <= 49'(w_mul_a) * 49'(w_mul_b);
        end
        case (i_cw.accop)
            ACC_LOAD: r_acc <= w_prod_x;
            ACC_ADD:  r_acc <= r_acc + w_prod_x;
            ACC_SUB:  r_acc <= r_acc - w_prod_x;
            default:  r_acc <= r_acc;
        endcase
        if (i_cw.op == OP_DIFF) begin
            r_dx <= {r_cur_x[PosW-1], r_cur_x} - {r_cx[PosW-1], r_cx};
            r_dy <= {r_cur_y[PosW-1], r_cur_y} - {r_cy[PosW-1], r_cy};
        end
        if (i_cw.wr == WR_LX) begin
            r_lx <= w_shift;
        end
        if (i_cw.wr == WR_LY) begin
            r_ly <= w_shift;
        end
        // Face of least penetration; a tie goes to X, zero pushes positive
        if (i_cw.op == OP_TEST) begin
            if (w_pen_x <= w_pen_y) begin
                r_nlx <= r_lx[35] ? -w_ex_s : w_ex_s;
                r_nly <= r_ly[21:0];
            end else begin
                r_nlx <= r_lx[21:0];
                r_nly <= r_ly[35] ? -w_ey_s : w_ey_s;
            end
        end
    end

    // Held position and push flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_any   <= 1'b0;
        end else begin
            if (i_cw.op == OP_LOAD && r_first) begin
                r_cur_x <= r_agent_x;
                r_cur_y <= r_agent_y;
                r_any   <= 1'b0;
            end
            if (i_cw.op == OP_TEST && w_inside) begin
                r_any <= 1'b1;
            end
            if (i_cw.wr == WR_PX) begin
                r_cur_x <= w_sat;
            end
            if (i_cw.wr == WR_PY) begin
                r_cur_y <= w_sat;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= {7'b0, r_any, r_cur_y, r_cur_x};
        end
    end

    assign o_status.outside    = !w_inside;
    assign o_status.emit_stall = w_stall;
    assign o_out_valid         = r_out_valid;
    assign o_out_data          = r_out_data;

endmodule

// File: hw/rtl/point_obb_pushout_resolver.sv
// ----------------------------------------------------------------------------
// Point versus oriented box push-out resolver
// Resolves an agent position against a run of oriented rectangles.
// ----------------------------------------------------------------------------
// The block takes one rectangle per input transaction; the first rectangle of
// a run (tuser high) also loads the agent position, and the last (tlast high)
// produces one output transaction with the resolved position and a moved flag.
// A 16-step control program runs one shared 33x16 multiplier over each
// rectangle; the next one is accepted only once the program ends, and a
// rectangle that does not push the agent jumps past the push steps.
// The result sits in an output register, so the next rectangle is accepted
// while it waits; the program holds on its last step only when a new result
// meets a result that has not been taken. The user must write the clearance
// register only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module point_obb_pushout_resolver
    import por_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration: clearance, Q.16 meters
    input  logic                i_cfg_wr_en,
    input  logic [ClrW-1:0]     i_cfg_wr_data,
    // Rectangle stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata from bit 0: agent_x[31:0], agent_y[63:32], box_cx[95:64],
    // box_cy[127:96], box_cos[143:128], box_sin[159:144], half_x[179:160],
    // half_y[199:180]
    input  logic [InDataW-1:0]  s_axis_tdata,
    // tuser: first
    input  logic                s_axis_tuser,
    // tlast: last
    input  logic                s_axis_tlast,
    // Result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata from bit 0: pos_x[31:0], pos_y[63:32], moved[64], zeros[71:65]
    output logic [OutDataW-1:0] m_axis_tdata
);

    t_cw        w_cw;
    t_dp_status w_status;
    logic       w_idle;
    logic       w_accept;

    assign s_axis_tready = w_idle;
    assign w_accept      = s_axis_tvalid && w_idle;

    por_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_status (w_status),
        .o_cw     (w_cw),
        .o_idle   (w_idle)
    );

    por_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_accept),
        .i_first       (s_axis_tuser),
        .i_last        (s_axis_tlast),
        .i_data        (s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cw          (w_cw),
        .o_status      (w_status),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata)
    );

    // An accepted rectangle starts the program, which runs at least two steps.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("ready returned too early after an accepted rectangle");

    // A new result appears only from the final program step.
    a_emit_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cw.op == OP_END))
        else $error("result raised outside the final step");

    // The program runs only while an item is held.
    a_idle_nop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_idle |-> (w_cw.op == OP_NOP && !w_cw.mul_en && w_cw.wr == WR_NONE))
        else $error("control word active while idle");

endmodule
